[design/sks_pkg.sv]
// Package for the scalar Kalman smoother: widths, microcode word and step codes.
`default_nettype none
package sks_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 16;
	localparam int REG_W         = 16;

	localparam int COV_W   = FRACTION_BITS + 2;
	localparam int PRED_W  = ((COV_W > REG_W) ? COV_W : REG_W) + 1;
	localparam int DEN_W   = ((PRED_W > REG_W) ? PRED_W : REG_W) + 1;
	localparam int REM_W   = DEN_W + 1;
	localparam int QUO_W   = FRACTION_BITS + 1;
	localparam int EST_W   = SAMPLE_BITS + FRACTION_BITS;
	localparam int MUL_A_W = FRACTION_BITS + 1;
	localparam int MUL_B_W = (EST_W > PRED_W) ? EST_W : PRED_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int CNT_W   = $clog2(QUO_W);

	localparam logic [REG_W-1:0] Q_RESET = REG_W'(66);
	localparam logic [REG_W-1:0] R_RESET = REG_W'(35586);
	localparam logic [COV_W-1:0] COV_RESET =
		COV_W'((((64'd1 << FRACTION_BITS) * 2) + 50) / 100);
	localparam logic [FRACTION_BITS-1:0] GAIN_MAX = '1;
	localparam logic [MUL_A_W-1:0] ONE_FX = MUL_A_W'(1) << FRACTION_BITS;

	// register indexes
	localparam logic REG_Q = 1'b0;
	localparam logic REG_R = 1'b1;

	// program steps
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_WAIT = 3'd0;
	localparam logic [PC_W-1:0] PC_PRED = 3'd1;
	localparam logic [PC_W-1:0] PC_DEN  = 3'd2;
	localparam logic [PC_W-1:0] PC_DIV  = 3'd3;
	localparam logic [PC_W-1:0] PC_GAIN = 3'd4;
	localparam logic [PC_W-1:0] PC_MUL  = 3'd5;
	localparam logic [PC_W-1:0] PC_UPDX = 3'd6;
	localparam logic [PC_W-1:0] PC_OUT  = 3'd7;

	// multiplier operand select
	localparam logic [1:0] MS_NONE = 2'd0;
	localparam logic [1:0] MS_KMAG = 2'd1;
	localparam logic [1:0] MS_COV  = 2'd2;

	// jump conditions: jump to target when the condition holds, else step on
	localparam logic [1:0] JC_NEVER  = 2'd0;
	localparam logic [1:0] JC_NO_IN  = 2'd1;
	localparam logic [1:0] JC_CNT_NZ = 2'd2;
	localparam logic [1:0] JC_BUSY   = 2'd3;

	typedef struct packed {
		logic            take_in;
		logic            ld_pred;
		logic            ld_den;
		logic            div_step;
		logic            ld_gain;
		logic [1:0]      mul_sel;
		logic            upd_x;
		logic            upd_p;
		logic            emit;
		logic [1:0]      jcond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic cnt_zero;
	} stat_t;

endpackage
`default_nettype wire

[design/scalar_kalman_smoother.sv]
// Items are worked one at a time: a new item is taken only once the last one's result
// is registered. The one-bit-a-step restoring divider and the shared multiplier, used
// twice, set the pace; a held result also holds the program at its output step.
// Reset: asynchronous, active low; covariance goes to 0.02, estimate to zero,
// noise registers to their defaults, no result pending.
`default_nettype none
module scalar_kalman_smoother import sks_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [2:0]               paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [SAMPLE_BITS-1:0]   sample,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic      [SAMPLE_BITS-1:0]   estimate_whole,
	output logic      [FRACTION_BITS-1:0] estimate_fraction,
	output logic      [FRACTION_BITS-1:0] gain
);

	logic [PC_W-1:0]          pc_q;
	logic [REG_W-1:0]         q_reg_q;
	logic [REG_W-1:0]         r_reg_q;
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   whole_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic [FRACTION_BITS-1:0] gain_q;

	ctrl_t                    ctrl;
	stat_t                    stat;
	logic [EST_W-1:0]         est;
	logic [FRACTION_BITS-1:0] k;
	logic                     in_take;
	logic                     busy;
	logic                     jump;
	logic                     wr_en;

	sks_ucode_rom u_rom (
		.pc   (pc_q),
		.ctrl (ctrl)
	);

	sks_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.in_take (in_take),
		.sample  (sample),
		.q_reg   (q_reg_q),
		.r_reg   (r_reg_q),
		.stat    (stat),
		.est     (est),
		.k       (k)
	);

	assign in_stall = !ctrl.take_in;
	assign in_take  = in_valid && ctrl.take_in;
	assign busy     = out_valid_q && out_stall;

	always_comb begin
		case (ctrl.jcond)
			JC_NO_IN:  jump = !in_take;
			JC_CNT_NZ: jump = !stat.cnt_zero;
			JC_BUSY:   jump = busy;
			default:   jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= PC_WAIT;
		else
			pc_q <= jump ? ctrl.target : (pc_q + PC_W'(1));
	end

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_R) ? 32'(r_reg_q) : 32'(q_reg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_reg_q <= Q_RESET;
			r_reg_q <= R_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_Q)
				q_reg_q <= pwdata[REG_W-1:0];
			else
				r_reg_q <= pwdata[REG_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.emit && !busy)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && !busy) begin
			whole_q <= est[EST_W-1 -: SAMPLE_BITS];
			frac_q  <= est[FRACTION_BITS-1:0];
			gain_q  <= k;
		end
	end

	assign out_valid         = out_valid_q;
	assign estimate_whole    = whole_q;
	assign estimate_fraction = frac_q;
	assign gain              = gain_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (pc_q == PC_PRED))
		else $error("accepted item did not start the program");

	a_result_from_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(pc_q) == PC_OUT))
		else $error("result raised outside the output step");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != PC_WAIT) |-> in_stall)
		else $error("input taken while an item is in work");

endmodule
`default_nettype wire

[design/sks_ucode_rom.sv]
// Microcode table: one control word per program step.
`default_nettype none
module sks_ucode_rom import sks_pkg::*; (
	input  wire logic [PC_W-1:0] pc,
	output ctrl_t                ctrl
);

	always_comb begin
		ctrl = '0;
		case (pc)
			PC_WAIT: begin
				ctrl.take_in = 1'b1;
				ctrl.jcond   = JC_NO_IN;
				ctrl.target  = PC_WAIT;
			end
			PC_PRED: ctrl.ld_pred = 1'b1;
			PC_DEN:  ctrl.ld_den  = 1'b1;
			PC_DIV: begin
				ctrl.div_step = 1'b1;
				ctrl.jcond    = JC_CNT_NZ;
				ctrl.target   = PC_DIV;
			end
			PC_GAIN: ctrl.ld_gain = 1'b1;
			PC_MUL:  ctrl.mul_sel = MS_KMAG;
			PC_UPDX: begin
				ctrl.upd_x   = 1'b1;
				ctrl.mul_sel = MS_COV;
			end
			PC_OUT: begin
				ctrl.upd_p  = 1'b1;
				ctrl.emit   = 1'b1;
				ctrl.jcond  = JC_BUSY;
				ctrl.target = PC_OUT;
			end
			default: ctrl = '0;
		endcase
	end

endmodule
`default_nettype wire

[design/sks_datapath.sv]
// Datapath: covariance and estimate state, restoring divider, shared multiplier.
`default_nettype none
module sks_datapath import sks_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ctrl_t                    ctrl,
	input  wire logic                     in_take,
	input  wire logic [SAMPLE_BITS-1:0]   sample,
	input  wire logic [REG_W-1:0]         q_reg,
	input  wire logic [REG_W-1:0]         r_reg,
	output stat_t                         stat,
	output logic      [EST_W-1:0]         est,
	output logic      [FRACTION_BITS-1:0] k
);

	logic [COV_W-1:0]         p_q;
	logic [EST_W-1:0]         x_q;
	logic [EST_W-1:0]         meas_q;
	logic [PRED_W-1:0]        pred_q;
	logic [DEN_W-1:0]         den_q;
	logic [REM_W-1:0]         rem_q;
	logic [QUO_W-1:0]         quot_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [FRACTION_BITS-1:0] k_q;
	logic [EST_W-1:0]         mag_q;
	logic                     up_q;
	logic [PROD_W-1:0]        prod_q;

	logic                     rem_ge;
	logic [REM_W-1:0]         rem_sub;
	logic [MUL_A_W-1:0]       mul_a;
	logic [MUL_B_W-1:0]       mul_b;
	logic [EST_W-1:0]         step;
	logic [PRED_W-1:0]        cov;
	logic [FRACTION_BITS-1:0] k_next;

	assign rem_ge  = rem_q >= REM_W'(den_q);
	assign rem_sub = rem_ge ? (rem_q - REM_W'(den_q)) : rem_q;

	always_comb begin
		if (den_q == '0)
			k_next = '0;
		else if (quot_q[QUO_W-1])
			k_next = GAIN_MAX;   // gain of exactly one saturates
		else
			k_next = quot_q[FRACTION_BITS-1:0];
	end

	always_comb begin
		case (ctrl.mul_sel)
			MS_KMAG: begin
				mul_a = MUL_A_W'(k_q);
				mul_b = MUL_B_W'(mag_q);
			end
			MS_COV: begin
				mul_a = ONE_FX - MUL_A_W'(k_q);
				mul_b = MUL_B_W'(pred_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign step = prod_q[FRACTION_BITS +: EST_W];
	assign cov  = prod_q[FRACTION_BITS +: PRED_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= COV_RESET;
			x_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (ctrl.ld_den)
				cnt_q <= CNT_W'(QUO_W - 1);
			else if (ctrl.div_step && cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
			if (ctrl.upd_x)
				x_q <= up_q ? (x_q + step) : (x_q - step);
			if (ctrl.upd_p)
				p_q <= ((cov >> COV_W) != '0) ? '1 : cov[COV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			meas_q <= {sample, {FRACTION_BITS{1'b0}}};
		if (ctrl.ld_pred)
			pred_q <= PRED_W'(p_q) + PRED_W'(q_reg);
		if (ctrl.ld_den) begin
			den_q  <= DEN_W'(pred_q) + DEN_W'(r_reg);
			rem_q  <= REM_W'(pred_q);
			quot_q <= '0;
		end
		if (ctrl.div_step) begin
			// remainder stays below the divisor, so the shift loses nothing
			rem_q  <= {rem_sub[REM_W-2:0], 1'b0};
			quot_q <= {quot_q[QUO_W-2:0], rem_ge};
		end
		if (ctrl.ld_gain) begin
			k_q   <= k_next;
			up_q  <= meas_q >= x_q;
			mag_q <= (meas_q >= x_q) ? (meas_q - x_q) : (x_q - meas_q);
		end
		if (ctrl.mul_sel != MS_NONE)
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign stat.cnt_zero = (cnt_q == '0);
	assign est = x_q;
	assign k   = k_q;

endmodule
`default_nettype wire

[tb/sv/scalar_kalman_smoother_tb.sv]
// Self-checking testbench for the scalar Kalman smoother: directed table, then random phases.
`default_nettype none
module scalar_kalman_smoother_tb import sks_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 40;
	localparam int SEG_ITEMS      = 172;

	// which fields of a table row carry a typed-in expectation
	localparam logic [2:0] CHK_NONE = 3'b000;
	localparam logic [2:0] CHK_GAIN = 3'b001;
	localparam logic [2:0] CHK_ALL  = 3'b111;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]   whole;
		logic [FRACTION_BITS-1:0] frac;
		logic [FRACTION_BITS-1:0] gain;
	} estimate_t;

	typedef struct packed {
		row_kind_t                kind;
		logic                     reg_idx;
		logic [REG_W-1:0]         value;
		logic [2:0]               chk;
		logic [SAMPLE_BITS-1:0]   whole;
		logic [FRACTION_BITS-1:0] frac;
		logic [FRACTION_BITS-1:0] gain;
	} row_t;

	localparam row_t PLAN [26] = '{
		'{ROW_ITEM, REG_Q, 16'd0,     CHK_ALL,  12'd0, 16'd0, 16'd2441}, // first step after reset
		'{ROW_ITEM, REG_Q, 16'd4095,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd4095,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd0,     CHK_NONE, 12'd0, 16'd0, 16'd0},    // negative innovation
		'{ROW_ITEM, REG_Q, 16'd2048,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_CFG,  REG_Q, 16'hFFFF,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_CFG,  REG_R, 16'hFFFF,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd4095,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd0,     CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd1,     CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_CFG,  REG_R, 16'd0,     CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd4095,  CHK_GAIN, 12'd0, 16'd0, 16'hFFFF}, // unit gain saturates
		'{ROW_ITEM, REG_Q, 16'd0,     CHK_GAIN, 12'd0, 16'd0, 16'hFFFF},
		'{ROW_ITEM, REG_Q, 16'd1,     CHK_GAIN, 12'd0, 16'd0, 16'hFFFF},
		'{ROW_CFG,  REG_Q, 16'd0,     CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd3000,  CHK_NONE, 12'd0, 16'd0, 16'd0},    // drains covariance to 0
		'{ROW_ITEM, REG_Q, 16'd4095,  CHK_GAIN, 12'd0, 16'd0, 16'd0},    // zero denominator
		'{ROW_ITEM, REG_Q, 16'd0,     CHK_GAIN, 12'd0, 16'd0, 16'd0},
		'{ROW_CFG,  REG_R, 16'd1,     CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd2000,  CHK_GAIN, 12'd0, 16'd0, 16'd0},
		'{ROW_CFG,  REG_Q, 16'd1,     CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd4095,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_CFG,  REG_Q, Q_RESET,   CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_CFG,  REG_R, R_RESET,   CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd1234,  CHK_NONE, 12'd0, 16'd0, 16'd0},
		'{ROW_ITEM, REG_Q, 16'd4095,  CHK_NONE, 12'd0, 16'd0, 16'd0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [2:0]               paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [SAMPLE_BITS-1:0]   sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [SAMPLE_BITS-1:0]   estimate_whole;
	logic [FRACTION_BITS-1:0] estimate_fraction;
	logic [FRACTION_BITS-1:0] gain;

	// predictor state
	logic [COV_W-1:0]       cov_model;
	logic [EST_W-1:0]       est_model;
	logic [REG_W-1:0]       q_model;
	logic [REG_W-1:0]       r_model;
	estimate_t              estimates_due[$];
	logic [SAMPLE_BITS-1:0] last_sample = '0;

	int fails = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	scalar_kalman_smoother dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.sample            (sample),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.estimate_whole    (estimate_whole),
		.estimate_fraction (estimate_fraction),
		.gain              (gain)
	);

	always #4 clk = ~clk;

	// one filter step on the predictor state
	function automatic estimate_t kalman_update(input logic [SAMPLE_BITS-1:0] s);
		logic [63:0] meas, pred, den, k, mag, delta, cov_next;
		estimate_t res;
		meas = 64'(s) << FRACTION_BITS;
		pred = 64'(cov_model) + 64'(q_model);
		den  = pred + 64'(r_model);
		k    = '0;
		if (den != 0) begin
			k = (pred << FRACTION_BITS) / den;
			if (k > 64'(GAIN_MAX))
				k = 64'(GAIN_MAX);
		end
		// truncate the magnitude first, so a step rounds toward zero either way
		if (meas >= 64'(est_model)) begin
			mag = meas - 64'(est_model);
			delta = (k * mag) >> FRACTION_BITS;
			est_model = EST_W'(64'(est_model) + delta);
		end else begin
			mag = 64'(est_model) - meas;
			delta = (k * mag) >> FRACTION_BITS;
			est_model = EST_W'(64'(est_model) - delta);
		end
		cov_next = (((64'd1 << FRACTION_BITS) - k) * pred) >> FRACTION_BITS;
		cov_model = (cov_next > ((64'd1 << COV_W) - 1)) ? '1 : COV_W'(cov_next);
		res.whole = est_model[EST_W-1 -: SAMPLE_BITS];
		res.frac  = est_model[FRACTION_BITS-1:0];
		res.gain  = k[FRACTION_BITS-1:0];
		return res;
	endfunction

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic [2:0] chk,
			input estimate_t typed);
		estimate_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = kalman_update(s);
		if (chk[2]) res.whole = typed.whole;
		if (chk[1]) res.frac = typed.frac;
		if (chk[0]) res.gain = typed.gain;
		estimates_due.push_back(res);
		last_sample = s;
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		@(posedge clk);
		while (estimates_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// write then read back one noise register; block must be idle
	task automatic write_noise(input logic idx, input logic [REG_W-1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(val)) begin
			$display("%0t: register %0d readback expected %0d got %0d", $time, idx, val, prdata);
			fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_Q)
			q_model = val;
		else
			r_model = val;
	endtask

	function automatic logic [REG_W-1:0] pick_noise;
		int roll;
		roll = $urandom_range(9);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		if (roll < 5) return REG_W'($urandom_range(4095));
		return REG_W'($urandom);
	endfunction

	// slowly wandering signal with jumps and rail hits
	function automatic logic [SAMPLE_BITS-1:0] pick_sample;
		int roll, walk;
		roll = $urandom_range(7);
		if (roll == 0)
			return $urandom_range(1) ? '1 : '0;
		if (roll < 4) begin
			walk = int'(last_sample) + $urandom_range(128) - 64;
			if (walk < 0) walk = 0;
			if (walk > (1 << SAMPLE_BITS) - 1) walk = (1 << SAMPLE_BITS) - 1;
			return SAMPLE_BITS'(walk);
		end
		return SAMPLE_BITS'($urandom);
	endfunction

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (estimates_due.size() == 0) begin
				$display("%0t: unexpected result %0d %0d %0d", $time,
					estimate_whole, estimate_fraction, gain);
				fails++;
			end else begin
				want = estimates_due.pop_front();
				if (estimate_whole !== want.whole) begin
					$display("%0t: estimate_whole expected %0d got %0d", $time,
						want.whole, estimate_whole);
					fails++;
				end
				if (estimate_fraction !== want.frac) begin
					$display("%0t: estimate_fraction expected %0d got %0d", $time,
						want.frac, estimate_fraction);
					fails++;
				end
				if (gain !== want.gain) begin
					$display("%0t: gain expected %0d got %0d", $time, want.gain, gain);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		estimate_t none;
		none = '0;
		cov_model = COV_RESET;
		est_model = '0;
		q_model = Q_RESET;
		r_model = R_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(PLAN); i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				wait_drained();
				write_noise(PLAN[i].reg_idx, PLAN[i].value);
			end else begin
				send_sample(SAMPLE_BITS'(PLAN[i].value), PLAN[i].chk,
					'{PLAN[i].whole, PLAN[i].frac, PLAN[i].gain});
			end
		end

		// phases: no idling, sender idle, receiver stalling, both
		for (int phase = 0; phase < 4; phase++) begin
			for (int seg = 0; seg < 2; seg++) begin
				wait_drained();
				send_idle_pct = (phase == 1) ? 73 : (phase == 3) ? 35 : 0;
				recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 35 : 0;
				write_noise(REG_Q, pick_noise());
				write_noise(REG_R, pick_noise());
				for (int n = 0; n < SEG_ITEMS; n++)
					send_sample(pick_sample(), CHK_NONE, none);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
design/sks_pkg.sv
design/sks_ucode_rom.sv
design/sks_datapath.sv
design/scalar_kalman_smoother.sv
tb/sv/scalar_kalman_smoother_tb.sv
